/* design/tpc_pkg.sv */
// Shared types, codes and the transition table of the two-phase commit coordinator.
// Used by tpc_ledger, tpc_fsm and two_phase_commit_coordinator. No dependencies.
`default_nettype none

package tpc_pkg;

	localparam int MaskW        = 16;
	localparam int IndexW       = 4;
	localparam int StampW       = 64;
	localparam int DefMaxParts  = 16;

	typedef enum logic [2:0] {
		ACT_LIST        = 3'd0,
		ACT_VOTE_COMMIT = 3'd1,
		ACT_VOTE_ABORT  = 3'd2,
		ACT_TRY_ABORT   = 3'd3,
		ACT_ACK         = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		ST_WAIT_LIST  = 3'd0,
		ST_WAIT_VOTES = 3'd1,
		ST_ABORTED    = 3'd2,
		ST_WAIT_ACKS  = 3'd3,
		ST_COMMITTED  = 3'd4,
		ST_BROKEN     = 3'd5
	} state_t;

	typedef enum logic [2:0] {
		EV_LIST         = 3'd0,
		EV_COMMIT       = 3'd1,
		EV_FINAL_COMMIT = 3'd2,
		EV_ABORT        = 3'd3,
		EV_TRY_ABORT    = 3'd4,
		EV_FINAL_ACK    = 3'd5
	} event_t;

	typedef enum logic [1:0] {
		CMD_NONE   = 2'd0,
		CMD_ABORT  = 2'd1,
		CMD_COMMIT = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		VOTE_UNKNOWN = 2'd0,
		VOTE_COMMIT  = 2'd1,
		VOTE_ABORT   = 2'd2
	} vote_t;

	typedef enum logic [2:0] {
		ERR_OK            = 3'd0,
		ERR_ILLEGAL       = 3'd1,
		ERR_UNKNOWN_PART  = 3'd2,
		ERR_CONFLICT      = 3'd3,
		ERR_STAMP         = 3'd4,
		ERR_LIST_MISMATCH = 3'd5,
		ERR_ACK_EARLY     = 3'd6
	} err_t;

	typedef struct packed {
		logic   legal;
		cmd_t   cmd;
		state_t next;
	} move_t;

	// event request from the ledger to the state machine
	typedef struct packed {
		logic   apply;
		event_t ev;
	} ev_req_t;

	typedef struct packed {
		state_t cur_state;
		state_t state;
		cmd_t   cmd;
		logic   illegal;
	} fsm_res_t;

	function automatic move_t move_lookup(state_t st, event_t ev);
		move_t mv;
		mv = '{legal: 1'b0, cmd: CMD_NONE, next: ST_BROKEN};
		case (st)
			ST_WAIT_LIST: begin
				case (ev)
					EV_LIST:      mv = '{1'b1, CMD_NONE, ST_WAIT_VOTES};
					EV_COMMIT:    mv = '{1'b1, CMD_NONE, ST_WAIT_LIST};
					EV_ABORT:     mv = '{1'b1, CMD_ABORT, ST_ABORTED};
					EV_TRY_ABORT: mv = '{1'b1, CMD_ABORT, ST_ABORTED};
					default:      mv = '{1'b0, CMD_NONE, ST_BROKEN};
				endcase
			end
			ST_WAIT_VOTES: begin
				case (ev)
					EV_LIST:         mv = '{1'b1, CMD_NONE, ST_WAIT_VOTES};
					EV_COMMIT:       mv = '{1'b1, CMD_NONE, ST_WAIT_VOTES};
					EV_FINAL_COMMIT: mv = '{1'b1, CMD_COMMIT, ST_WAIT_ACKS};
					EV_ABORT:        mv = '{1'b1, CMD_ABORT, ST_ABORTED};
					EV_TRY_ABORT:    mv = '{1'b1, CMD_ABORT, ST_ABORTED};
					default:         mv = '{1'b0, CMD_NONE, ST_BROKEN};
				endcase
			end
			ST_ABORTED: begin
				case (ev)
					EV_LIST, EV_COMMIT, EV_ABORT, EV_TRY_ABORT:
						mv = '{1'b1, CMD_NONE, ST_ABORTED};
					default: mv = '{1'b0, CMD_NONE, ST_BROKEN};
				endcase
			end
			ST_WAIT_ACKS: begin
				case (ev)
					EV_LIST, EV_COMMIT, EV_TRY_ABORT:
						mv = '{1'b1, CMD_NONE, ST_WAIT_ACKS};
					EV_FINAL_COMMIT: mv = '{1'b1, CMD_COMMIT, ST_WAIT_ACKS};
					EV_FINAL_ACK:    mv = '{1'b1, CMD_NONE, ST_COMMITTED};
					default:         mv = '{1'b0, CMD_NONE, ST_BROKEN};
				endcase
			end
			ST_COMMITTED: begin
				case (ev)
					EV_ABORT: mv = '{1'b0, CMD_NONE, ST_BROKEN};
					default:  mv = '{1'b1, CMD_NONE, ST_COMMITTED};
				endcase
			end
			default: mv = '{1'b0, CMD_NONE, ST_BROKEN};
		endcase
		return mv;
	endfunction

endpackage

`default_nettype wire

/* design/tpc_fsm.sv */
// Coordinator state machine: holds the protocol state and applies the transition table.
// Depends on tpc_pkg.
`default_nettype none

module tpc_fsm
	import tpc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step,
	input  ev_req_t   req,
	output fsm_res_t  res
);

	state_t state_q;
	state_t next_state;
	move_t  mv;

	assign mv = move_lookup(state_q, req.ev);

	// next state
	always_comb begin
		next_state = state_q;
		if (req.apply) begin
			next_state = mv.legal ? mv.next : ST_BROKEN;
		end
	end

	// outputs
	always_comb begin
		res.cur_state = state_q;
		res.state     = next_state;
		res.cmd       = (req.apply && mv.legal) ? mv.cmd : CMD_NONE;
		res.illegal   = req.apply && !mv.legal;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WAIT_LIST;
		end else if (step) begin
			state_q <= next_state;
		end
	end

endmodule

`default_nettype wire

/* design/tpc_ledger.sv */
// Participant bookkeeping: known set, votes, prepare stamps, acks and highest stamp.
// Decodes each request into a table event. Depends on tpc_pkg.
`default_nettype none

module tpc_ledger
	import tpc_pkg::*;
#(
	parameter int MAX_PARTICIPANTS = DefMaxParts
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  action_t                action,
	input  wire logic [IndexW-1:0] participant_index,
	input  wire logic [MaskW-1:0]  participant_mask,
	input  wire logic [StampW-1:0] prepare_stamp,
	output ev_req_t                req,
	output err_t                   err,
	output logic [StampW-1:0]      max_stamp
);

	localparam int NumSlots = (MAX_PARTICIPANTS < MaskW) ? MAX_PARTICIPANTS : MaskW;
	localparam int SlotW    = (NumSlots > 1) ? $clog2(NumSlots) : 1;

	logic                list_q, list_nxt;
	logic [NumSlots-1:0] known_q, known_nxt;
	logic [NumSlots-1:0] ack_q, ack_nxt;
	logic [StampW-1:0]   max_q, max_nxt;
	vote_t               vote_q [NumSlots];
	logic [StampW-1:0]   stamp_q [NumSlots];

	logic                in_range;
	logic [SlotW-1:0]    slot;
	logic [NumSlots-1:0] bit_vec;
	logic [NumSlots-1:0] mask_in;
	logic [NumSlots-1:0] commit_vec;
	vote_t               vote_cur;
	logic                vote_we, stamp_we;
	vote_t               vote_wval;

	assign in_range = ({1'b0, participant_index} < (IndexW + 1)'(NumSlots));
	assign slot     = participant_index[SlotW-1:0];
	assign bit_vec  = in_range ? (NumSlots'(1) << slot) : '0;
	assign mask_in  = participant_mask[NumSlots-1:0];
	assign vote_cur = vote_q[slot];

	always_comb begin
		for (int i = 0; i < NumSlots; i++) begin
			commit_vec[i] = (vote_q[i] == VOTE_COMMIT);
		end
	end

	always_comb begin
		known_nxt = known_q;
		list_nxt  = list_q;
		ack_nxt   = ack_q;
		max_nxt   = max_q;
		vote_we   = 1'b0;
		vote_wval = VOTE_UNKNOWN;
		stamp_we  = 1'b0;
		req       = '{apply: 1'b0, ev: EV_LIST};
		err       = ERR_OK;
		case (action)
			ACT_LIST: begin
				if (!list_q) begin
					known_nxt = known_q | mask_in;
				end
				list_nxt = 1'b1;
				if (mask_in != known_nxt) begin
					err = ERR_LIST_MISMATCH;
				end else begin
					req = '{apply: 1'b1, ev: EV_LIST};
				end
			end
			ACT_VOTE_COMMIT, ACT_VOTE_ABORT: begin
				// before the list, voters join the known set
				if (!list_q) begin
					known_nxt = known_q | bit_vec;
				end
				if ((known_nxt & bit_vec) == '0) begin
					err = ERR_UNKNOWN_PART;
				end else if (action == ACT_VOTE_COMMIT) begin
					if (vote_cur == VOTE_ABORT) begin
						err = ERR_CONFLICT;
					end else if (vote_cur == VOTE_COMMIT && stamp_q[slot] != prepare_stamp) begin
						err = ERR_STAMP;
					end else begin
						if (vote_cur == VOTE_UNKNOWN) begin
							vote_we   = 1'b1;
							vote_wval = VOTE_COMMIT;
							stamp_we  = 1'b1;
							if (prepare_stamp > max_q) begin
								max_nxt = prepare_stamp;
							end
						end
						if (list_q && ((known_nxt & ~(commit_vec | bit_vec)) == '0)) begin
							req = '{apply: 1'b1, ev: EV_FINAL_COMMIT};
						end else begin
							req = '{apply: 1'b1, ev: EV_COMMIT};
						end
					end
				end else begin
					if (vote_cur == VOTE_COMMIT) begin
						err = ERR_CONFLICT;
					end else begin
						vote_we   = 1'b1;
						vote_wval = VOTE_ABORT;
						req       = '{apply: 1'b1, ev: EV_ABORT};
					end
				end
			end
			ACT_TRY_ABORT: begin
				req = '{apply: 1'b1, ev: EV_TRY_ABORT};
			end
			ACT_ACK: begin
				if ((known_q & bit_vec) == '0) begin
					err = ERR_UNKNOWN_PART;
				end else begin
					ack_nxt = ack_q | bit_vec;
					if (!list_q) begin
						err = ERR_ACK_EARLY;
					end else if ((known_q & ~ack_nxt) == '0) begin
						req = '{apply: 1'b1, ev: EV_FINAL_ACK};
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign max_stamp = max_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_q  <= 1'b0;
			known_q <= '0;
			ack_q   <= '0;
			max_q   <= '0;
			for (int i = 0; i < NumSlots; i++) begin
				vote_q[i] <= VOTE_UNKNOWN;
			end
		end else if (step) begin
			list_q  <= list_nxt;
			known_q <= known_nxt;
			ack_q   <= ack_nxt;
			max_q   <= max_nxt;
			if (vote_we) begin
				vote_q[slot] <= vote_wval;
			end
		end
	end

	// stamps are only read after a commit vote wrote them
	always_ff @(posedge clk) begin
		if (step && stamp_we) begin
			stamp_q[slot] <= prepare_stamp;
		end
	end

endmodule

`default_nettype wire

/* design/two_phase_commit_coordinator.sv */
// Top level of the two-phase commit coordinator: input register, ledger, state machine
// and result register. Depends on tpc_pkg, tpc_ledger and tpc_fsm.
//
//  port group | dir | payload (lowest bit first)
//  s_*        | in  | tuser: action[2:0]; tdata: participant_index[3:0],
//             |     |   participant_mask[19:4], prepare_stamp[83:20], zero[87:84]
//  m_*        | out | tdata: command[1:0], coordinator_state[4:2], error_code[7:5],
//             |     |   highest_stamp[71:8]
//
// One request per cycle unless the output stalls: each request is held in the input
// register, evaluated against the ledger and state machine, and its result lands in the
// output register.
// Reset clears the protocol state, votes, acks and highest stamp at once; no clearing pass.
// A stalled output holds the input register, and s_tready drops only while both are full
// and m_tready is low.
`default_nettype none

module two_phase_commit_coordinator
	import tpc_pkg::*;
#(
	parameter int MAX_PARTICIPANTS = DefMaxParts
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [87:0] s_tdata,  // participant_index, participant_mask, prepare_stamp
	input  wire logic [2:0]  s_tuser,  // action
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata   // command, coordinator_state, error_code, highest_stamp
);

	logic              valid_s1;
	action_t           action_s1;
	logic [IndexW-1:0] index_s1;
	logic [MaskW-1:0]  mask_s1;
	logic [StampW-1:0] stamp_s1;

	logic              m_valid_q;
	logic [71:0]       m_data_q;

	logic              step;
	ev_req_t           req;
	err_t              ledger_err;
	err_t              res_err;
	logic [StampW-1:0] max_stamp;
	fsm_res_t          fres;

	assign step     = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || step;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	tpc_ledger #(
		.MAX_PARTICIPANTS(MAX_PARTICIPANTS)
	) u_ledger (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (step),
		.action           (action_s1),
		.participant_index(index_s1),
		.participant_mask (mask_s1),
		.prepare_stamp    (stamp_s1),
		.req              (req),
		.err              (ledger_err),
		.max_stamp        (max_stamp)
	);

	tpc_fsm u_fsm (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step),
		.req   (req),
		.res   (fres)
	);

	assign res_err = req.apply ? (fres.illegal ? ERR_ILLEGAL : ERR_OK) : ledger_err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (step) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1 <= action_t'(s_tuser);
			index_s1  <= s_tdata[3:0];
			mask_s1   <= s_tdata[19:4];
			stamp_s1  <= s_tdata[83:20];
		end
		if (step) begin
			m_data_q <= {max_stamp, res_err, fres.state, fres.cmd};
		end
	end

`ifndef SYNTHESIS
	a_broken_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		fres.cur_state == ST_BROKEN |=> fres.cur_state == ST_BROKEN)
		else $error("coordinator left the broken state");

	a_cmd_without_error: assert property (@(posedge clk) disable iff (!arst_n)
		step && fres.cmd != CMD_NONE |-> res_err == ERR_OK)
		else $error("command issued together with an error");

	a_illegal_breaks: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_err == ERR_ILLEGAL |=> m_tdata[4:2] == ST_BROKEN)
		else $error("illegal event did not report the broken state");

	a_stalled_item_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !step |=> valid_s1 && $stable(stamp_s1) && $stable(index_s1))
		else $error("held request lost while output stalled");

	a_stamp_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> max_stamp >= $past(max_stamp))
		else $error("highest stamp went down");
`endif

endmodule

`default_nettype wire
